// ===== hdl/eafrm_pkg.sv =====
package eafrm_pkg;

  localparam int IN_W      = 16;
  localparam int THR_W     = 15;
  localparam int STAGES    = 16;
  localparam int CW        = 36;   // CORDIC x/y width: 17-bit operand << 16, growth
  localparam int ZW        = 34;   // binary angle, 2^32 per turn, plus headroom
  localparam int SQ_W      = 29;   // radicand width (one*one = 2^28)
  localparam int RT_W      = 15;   // root width
  localparam int SQ_STEPS  = 15;
  localparam int QDEPTH    = 2;
  localparam int LIM90     = 90 * 128;
  localparam int LIM180    = 180 * 128;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zw_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [16:0] py;   // pitch y (clamped m21)
    logic signed [16:0] px;   // pitch x (C)
    logic signed [16:0] ry;
    logic signed [16:0] rx;
    logic signed [16:0] yy;
    logic signed [16:0] yx;
    logic               lock;
  } job_t;

  function automatic logic [ZW-1:0] atan_entry(input int i);
    logic [ZW-1:0] t [0:31];
    t = '{34'd536870912, 34'd316933406, 34'd167458907, 34'd85004756, 34'd42667331,
          34'd21354465, 34'd10679838, 34'd5340245, 34'd2670163, 34'd1335087,
          34'd667544, 34'd333772, 34'd166886, 34'd83443, 34'd41722, 34'd20861,
          34'd10430, 34'd5215, 34'd2608, 34'd1304, 34'd652, 34'd326, 34'd163,
          34'd81, 34'd41, 34'd20, 34'd10, 34'd5, 34'd3, 34'd1, 34'd1, 34'd0};
    return t[i];
  endfunction

endpackage

// ===== hdl/eafrm_front.sv =====
// Clamp m21, take the integer square root of 1 - m21^2 one bit per stage,
// then decide the gimbal-lock branch. Pipelined, one item per cycle while out_ready does not stall it.
module eafrm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7*16-1:0]           in_data,
  input  logic [14:0]               thr,
  output logic                      out_valid,
  input  logic                      out_ready,
  output eafrm_pkg::job_t           out_job
);
  import eafrm_pkg::*;

  localparam int NS = SQ_STEPS + 2;

  logic              v   [0:NS-1];
  logic [SQ_W-1:0]   rem [0:NS-2];
  logic [SQ_W-1:0]   res [0:NS-2];
  job_t              jb  [0:NS-1];
  job_t              cls;
  logic              adv;
  logic [15:0]       in_m10_q [0:NS-2];
  logic [15:0]       in_m00_q [0:NS-2];

  assign adv      = !v[NS-1] || out_ready;
  assign in_ready = adv;

  // stage 0: clamp and square
  logic signed [15:0] e21;
  logic signed [16:0] c21;
  logic signed [33:0] sq;
  always_comb begin
    e21 = in_data[5*16 +: 16];
    if (e21 > 16'sd16384)       c21 = 17'sd16384;
    else if (e21 < -16'sd16384) c21 = -17'sd16384;
    else                        c21 = 17'(e21);
    sq = 34'(c21) * 34'(c21);
  end

  // classify: attach the root and pick the roll operands for the lock branch
  always_comb begin
    cls      = jb[NS-2];
    cls.px   = 17'(res[NS-2][RT_W-1:0]);
    cls.lock = !(res[NS-2][RT_W-1:0] > thr);
    if (cls.lock) begin
      cls.ry = -17'(signed'(in_m10_q[NS-2]));
      cls.rx = 17'(signed'(in_m00_q[NS-2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) v[i] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
      for (int i = 1; i < NS; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]   <= SQ_W'(34'sd268435456 - sq);
      res[0]   <= '0;
      jb[0].py <= c21;
      jb[0].px <= '0;
      jb[0].ry <= -17'(signed'(in_data[4*16 +: 16]));
      jb[0].rx <= 17'(signed'(in_data[6*16 +: 16]));
      jb[0].yy <= -17'(signed'(in_data[1*16 +: 16]));
      jb[0].yx <= 17'(signed'(in_data[3*16 +: 16]));
      jb[0].lock <= 1'b0;
      // restoring square root, one result bit per stage
      for (int i = 1; i <= SQ_STEPS; i++) begin
        logic [SQ_W-1:0] b, t;
        b = SQ_W'(1) << (2 * (SQ_STEPS - i));
        t = res[i-1] + b;
        if (rem[i-1] >= t) begin
          rem[i] <= rem[i-1] - t;
          res[i] <= (res[i-1] >> 1) + b;
        end else begin
          rem[i] <= rem[i-1];
          res[i] <= res[i-1] >> 1;
        end
        jb[i] <= jb[i-1];
      end
      jb[NS-1] <= cls;
    end
  end

  // carry m10 and m00 along for the lock branch
  always_ff @(posedge clk) begin
    if (adv) begin
      in_m10_q[0] <= in_data[2*16 +: 16];
      in_m00_q[0] <= in_data[0 +: 16];
      for (int i = 1; i < NS-1; i++) begin
        in_m10_q[i] <= in_m10_q[i-1];
        in_m00_q[i] <= in_m00_q[i-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_job   = jb[NS-1];
endmodule

// ===== hdl/eafrm_queue.sv =====
// Two-entry queue that parts the front from the back.
module eafrm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  eafrm_pkg::job_t in_job,
  output logic            out_valid,
  input  logic            out_ready,
  output eafrm_pkg::job_t out_job
);
  import eafrm_pkg::*;

  job_t       mem [0:QDEPTH-1];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign in_ready  = cnt != 2'(QDEPTH);
  assign out_valid = cnt != 2'd0;
  assign out_job   = mem[rp];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_job;
  end
endmodule

// ===== hdl/eafrm_cordic.sv =====
// Pipelined vectoring CORDIC atan2 plus degree conversion; stall-aware.
module eafrm_cordic (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [16:0] y_in,
  input  logic signed [16:0] x_in,
  input  logic               sat90,
  output logic signed [15:0] deg
);
  import eafrm_pkg::*;

  cw_t  x [0:STAGES];
  cw_t  y [0:STAGES];
  zw_t  z [0:STAGES];
  logic zr [0:STAGES];
  logic s90 [0:STAGES+1];

  logic [ZW-1:0] mag;
  logic [ZW+15:0] prod;
  logic [17:0]   r;
  logic          neg;
  logic [15:0]   lim;

  always_ff @(posedge clk) begin
    if (adv) begin
      // quadrant pre-rotation
      zr[0]  <= (x_in == 0) && (y_in == 0);
      s90[0] <= sat90;
      if (x_in < 0) begin
        z[0] <= (y_in >= 0) ? ZW'(64'sd2147483648) : -ZW'(64'sd2147483648);
        x[0] <= CW'(-x_in) <<< 16;
        y[0] <= CW'(-y_in) <<< 16;
      end else begin
        z[0] <= '0;
        x[0] <= CW'(x_in) <<< 16;
        y[0] <= CW'(y_in) <<< 16;
      end
      // vectoring stages
      for (int i = 0; i < STAGES; i++) begin
        zr[i+1]  <= zr[i];
        s90[i+1] <= s90[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + signed'(atan_entry(i));
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - signed'(atan_entry(i));
        end
      end
      // split the angle into sign and magnitude
      neg  <= z[STAGES] < 0 && !zr[STAGES];
      mag  <= zr[STAGES] ? '0 : (z[STAGES] < 0 ? ZW'(-z[STAGES]) : ZW'(z[STAGES]));
      s90[STAGES+1] <= s90[STAGES];
    end
  end

  // scale: mag*360*128 / 2^32, round half away, saturate
  always_comb begin
    prod = (ZW+16)'(mag) * (ZW+16)'(46080);
    r    = 18'((prod + (ZW+16)'(64'd2147483648)) >> 32);
    lim  = s90[STAGES+1] ? 16'(LIM90) : 16'(LIM180);
    if (r > 18'(lim)) r = 18'(lim);
    deg  = neg ? -16'(r) : 16'(r);
  end
endmodule

// ===== hdl/eafrm_back.sv =====
// Three CORDIC pipes side by side; the degree scaling after their sign/magnitude register feeds the sink.
module eafrm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  eafrm_pkg::job_t in_job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [47:0]     out_data,
  output logic            out_lock
);
  import eafrm_pkg::*;

  localparam int NL = STAGES + 2;

  logic v [0:NL-1];
  logic lk [0:NL-1];
  logic adv;
  logic signed [15:0] pd, rd, yd;

  assign adv      = !v[NL-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NL; i++) v[i] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
      for (int i = 1; i < NL; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lk[0] <= in_job.lock;
      for (int i = 1; i < NL; i++) lk[i] <= lk[i-1];
    end
  end

  eafrm_cordic u_pitch (.clk, .adv, .y_in(in_job.py), .x_in(in_job.px), .sat90(1'b1),
                        .deg(pd));
  eafrm_cordic u_roll  (.clk, .adv, .y_in(in_job.ry), .x_in(in_job.rx), .sat90(1'b0),
                        .deg(rd));
  eafrm_cordic u_yaw   (.clk, .adv, .y_in(in_job.yy), .x_in(in_job.yx), .sat90(1'b0),
                        .deg(yd));

  // fields: yaw_deg[15:0], pitch_deg[30:16], roll_deg[46:31], zero pad
  assign out_valid = v[NL-1];
  assign out_lock  = lk[NL-1];
  assign out_data  = {1'b0, rd, pd[14:0], (lk[NL-1] ? 16'sd0 : yd)};
endmodule

// ===== hdl/euler_angles_from_rotation_matrix_unit.sv =====
// Euler angles from seven rotation-matrix entries (Q1.14) to yaw, pitch and roll in
// degrees with 7 fraction bits. Fully pipelined: one matrix accepted per cycle unless the
// sink stalls the output; the front holds the 15-step square root and the back the 16-stage
// CORDIC pipes. cos_threshold may be written only while the block is idle.
module euler_angles_from_rotation_matrix_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // m00, m01, m10, m11, m20, m21, m22
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // yaw_deg, pitch_deg, roll_deg, pad
  output logic         m_axis_tuser,  // gimbal_lock
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [14:0]  cfg_data
);
  import eafrm_pkg::*;

  logic [14:0] thr;
  logic        fv, fr, qv, qr;
  job_t        fj, qj;

  assign cfg_ready = 1'b1;

  // hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) thr <= 15'd1;
    else if (cfg_valid) thr <= cfg_data;
  end

  eafrm_front u_front (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .thr, .out_valid(fv), .out_ready(fr), .out_job(fj));
  eafrm_queue u_queue (.clk, .rst, .in_valid(fv), .in_ready(fr), .in_job(fj),
    .out_valid(qv), .out_ready(qr), .out_job(qj));
  eafrm_back u_back (.clk, .rst, .in_valid(qv), .in_ready(qr), .in_job(qj),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .out_lock(m_axis_tuser));

  a_lock_yaw: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("yaw not zero in gimbal lock");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule
